// ----- rtl/core/ucft_pkg.sv -----
`timescale 1ns / 1ps
// Package for the upload credit flow tracker: command codes, target codes
// and register widths. No dependencies.
package ucft_pkg;

    localparam int unsigned AMOUNT_W = 32;
    localparam int unsigned WINDOW_W = 17;
    localparam int unsigned TARGET_W = 2;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 17'd4096;

    typedef enum logic [2:0] {
        FUNC_BEGIN         = 3'd0,
        FUNC_BEGIN_CREDIT  = 3'd1,
        FUNC_NOTE_BYTES    = 3'd2,
        FUNC_PLAN          = 3'd3,
        FUNC_CREDIT_RESULT = 3'd4,
        FUNC_FINALIZE      = 3'd5,
        FUNC_TERMINAL      = 3'd6,
        FUNC_ABORT         = 3'd7
    } func_t;

    localparam logic [TARGET_W-1:0] TGT_NONE    = 2'd0;
    localparam logic [TARGET_W-1:0] TGT_SCANNER = 2'd1;
    localparam logic [TARGET_W-1:0] TGT_UPLINK  = 2'd2;
    localparam logic [TARGET_W-1:0] TGT_INVALID = 2'd3;

endpackage

// ----- rtl/core/upload_credit_flow_tracker.sv -----
// Upload credit flow tracker.
// Requests land in an input register; the state update and result are computed from it and
// written to a result register. Throughput is one request per cycle while the result is not
// stalled. While a result waits, one more request can sit in the input register.
// Reset (aresetn low, synchronous) clears the upload state and both valid flags, and sets
// the credit window to 4096 bytes.
`timescale 1ns / 1ps
// Top level of the upload credit flow tracker. Depends on ucft_pkg.
module upload_credit_flow_tracker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [16:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_func,
    input  logic [1:0]  s_target,
    input  logic [31:0] s_amount,
    input  logic        s_delivered,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_ok,
    output logic [1:0]  m_prev_target,
    output logic [31:0] m_allowed_bytes,
    output logic        m_credit_enabled,
    output logic        m_grant_wait,
    output logic [31:0] m_grant_amount,
    output logic [1:0]  m_active_target,
    output logic [31:0] m_bytes_received
);

    logic [ucft_pkg::WINDOW_W-1:0] window_reg;

    // Input stage.
    logic                          in_valid_reg;
    ucft_pkg::func_t               in_func_reg;
    logic [ucft_pkg::TARGET_W-1:0] in_target_reg;
    logic [ucft_pkg::AMOUNT_W-1:0] in_amount_reg;
    logic                          in_delivered_reg;
    logic                          advance;

    // Upload state.
    logic [ucft_pkg::TARGET_W-1:0] cur_target_reg, cur_target_next;
    logic [ucft_pkg::AMOUNT_W-1:0] total_size_reg, total_size_next;
    logic [ucft_pkg::AMOUNT_W-1:0] received_reg, received_next;
    logic                          credit_mode_reg, credit_mode_next;
    logic [ucft_pkg::AMOUNT_W-1:0] credit_left_reg, credit_left_next;
    logic [ucft_pkg::AMOUNT_W-1:0] credit_queued_reg, credit_queued_next;
    logic                          awaiting_reg, awaiting_next;
    logic                          finalized_reg, finalized_next;

    // Result stage.
    logic                          out_valid_reg;
    logic                          ok_next;
    logic [ucft_pkg::TARGET_W-1:0] prev_next;
    logic [ucft_pkg::AMOUNT_W-1:0] allowed_next;
    logic                          enabled_next;
    logic                          pending_next;
    logic                          ok_reg;
    logic [ucft_pkg::TARGET_W-1:0] prev_reg;
    logic [ucft_pkg::AMOUNT_W-1:0] allowed_reg;
    logic                          enabled_reg;
    logic                          pending_reg;
    logic [ucft_pkg::AMOUNT_W-1:0] grant_amount_reg;
    logic [ucft_pkg::TARGET_W-1:0] active_reg;
    logic [ucft_pkg::AMOUNT_W-1:0] bytes_reg;

    // Datapath terms.
    logic [ucft_pkg::AMOUNT_W-1:0] window32;
    logic [ucft_pkg::AMOUNT_W-1:0] remaining;
    logic [ucft_pkg::AMOUNT_W-1:0] remaining_after;
    logic [ucft_pkg::AMOUNT_W-1:0] left_after;
    logic                          amount_nz;
    logic                          begin_ok;
    logic                          note_ok;
    logic                          plan_ok;
    logic                          cur_enabled;
    logic                          cur_pending;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign window32        = {{(ucft_pkg::AMOUNT_W - ucft_pkg::WINDOW_W){1'b0}}, window_reg};
    assign remaining       = total_size_reg - received_reg;
    assign remaining_after = remaining - in_amount_reg;
    assign left_after      = credit_left_reg - in_amount_reg;
    assign amount_nz       = in_amount_reg != '0;
    assign cur_enabled     = (cur_target_reg == ucft_pkg::TGT_SCANNER) && credit_mode_reg;
    assign cur_pending     = cur_enabled && awaiting_reg && (credit_queued_reg != '0);

    assign begin_ok = (cur_target_reg == ucft_pkg::TGT_NONE) && amount_nz &&
                      ((in_target_reg == ucft_pkg::TGT_SCANNER) ||
                       (in_target_reg == ucft_pkg::TGT_UPLINK));

    assign note_ok = (cur_target_reg != ucft_pkg::TGT_NONE) && amount_nz &&
                     !(received_reg > total_size_reg) &&
                     !(credit_mode_reg && (awaiting_reg || (in_amount_reg > credit_left_reg))) &&
                     !(in_amount_reg > remaining);

    assign plan_ok = cur_enabled && !awaiting_reg && amount_nz &&
                     (received_reg < total_size_reg) &&
                     (in_amount_reg <= remaining) &&
                     (in_amount_reg <= credit_left_reg);

    always_comb begin
        cur_target_next    = cur_target_reg;
        total_size_next    = total_size_reg;
        received_next      = received_reg;
        credit_mode_next   = credit_mode_reg;
        credit_left_next   = credit_left_reg;
        credit_queued_next = credit_queued_reg;
        awaiting_next      = awaiting_reg;
        finalized_next     = finalized_reg;
        ok_next            = 1'b0;
        prev_next          = ucft_pkg::TGT_NONE;
        allowed_next       = '0;

        unique case (in_func_reg)
            ucft_pkg::FUNC_BEGIN: begin
                if (begin_ok) begin
                    cur_target_next = in_target_reg;
                    total_size_next = in_amount_reg;
                    ok_next         = 1'b1;
                end
            end
            ucft_pkg::FUNC_BEGIN_CREDIT: begin
                if (begin_ok && (in_target_reg == ucft_pkg::TGT_SCANNER)) begin
                    cur_target_next  = in_target_reg;
                    total_size_next  = in_amount_reg;
                    credit_mode_next = 1'b1;
                    credit_left_next = (in_amount_reg < window32) ? in_amount_reg : window32;
                    ok_next          = 1'b1;
                end
            end
            ucft_pkg::FUNC_NOTE_BYTES: begin
                if (note_ok) begin
                    received_next = received_reg + in_amount_reg;
                    ok_next       = 1'b1;
                    if (credit_mode_reg) begin
                        credit_left_next = left_after;
                        // The window ran dry before the end: queue the next grant.
                        if ((remaining_after != '0) && (left_after == '0)) begin
                            credit_queued_next = (remaining_after < window32) ?
                                                 remaining_after : window32;
                            awaiting_next      = 1'b1;
                        end
                    end
                end
            end
            ucft_pkg::FUNC_PLAN: begin
                if (plan_ok) begin
                    allowed_next = in_amount_reg;
                    ok_next      = 1'b1;
                end
            end
            ucft_pkg::FUNC_CREDIT_RESULT: begin
                if (in_delivered_reg && cur_pending) begin
                    credit_left_next   = credit_queued_reg;
                    credit_queued_next = '0;
                    awaiting_next      = 1'b0;
                    ok_next            = 1'b1;
                end
            end
            ucft_pkg::FUNC_FINALIZE: begin
                if ((cur_target_reg != ucft_pkg::TGT_NONE) &&
                    (received_reg == total_size_reg)) begin
                    finalized_next = 1'b1;
                    ok_next        = 1'b1;
                end
            end
            ucft_pkg::FUNC_TERMINAL, ucft_pkg::FUNC_ABORT: begin
                if (in_func_reg == ucft_pkg::FUNC_TERMINAL) begin
                    ok_next = (cur_target_reg == ucft_pkg::TGT_SCANNER) &&
                              finalized_reg && in_delivered_reg;
                end else begin
                    ok_next   = 1'b1;
                    prev_next = cur_target_reg;
                end
                cur_target_next    = ucft_pkg::TGT_NONE;
                total_size_next    = '0;
                received_next      = '0;
                credit_mode_next   = 1'b0;
                credit_left_next   = '0;
                credit_queued_next = '0;
                awaiting_next      = 1'b0;
                finalized_next     = 1'b0;
            end
        endcase

        enabled_next = (cur_target_next == ucft_pkg::TGT_SCANNER) && credit_mode_next;
        pending_next = enabled_next && awaiting_next && (credit_queued_next != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg        <= ucft_pkg::WINDOW_RESET;
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            cur_target_reg    <= ucft_pkg::TGT_NONE;
            total_size_reg    <= '0;
            received_reg      <= '0;
            credit_mode_reg   <= 1'b0;
            credit_left_reg   <= '0;
            credit_queued_reg <= '0;
            awaiting_reg      <= 1'b0;
            finalized_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                window_reg <= cfg_wdata;
            end
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg     <= 1'b1;
                cur_target_reg    <= cur_target_next;
                total_size_reg    <= total_size_next;
                received_reg      <= received_next;
                credit_mode_reg   <= credit_mode_next;
                credit_left_reg   <= credit_left_next;
                credit_queued_reg <= credit_queued_next;
                awaiting_reg      <= awaiting_next;
                finalized_reg     <= finalized_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_func_reg      <= ucft_pkg::func_t'(s_func);
            in_target_reg    <= s_target;
            in_amount_reg    <= s_amount;
            in_delivered_reg <= s_delivered;
        end
        if (advance) begin
            ok_reg           <= ok_next;
            prev_reg         <= prev_next;
            allowed_reg      <= allowed_next;
            enabled_reg      <= enabled_next;
            pending_reg      <= pending_next;
            grant_amount_reg <= pending_next ? credit_queued_next : '0;
            active_reg       <= cur_target_next;
            bytes_reg        <= received_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_ok             = ok_reg;
    assign m_prev_target    = prev_reg;
    assign m_allowed_bytes  = allowed_reg;
    assign m_credit_enabled = enabled_reg;
    assign m_grant_wait     = pending_reg;
    assign m_grant_amount   = grant_amount_reg;
    assign m_active_target  = active_reg;
    assign m_bytes_received = bytes_reg;

`ifndef SYNTHESIS
    // Credit mode is only ever entered toward the scanner target.
    a_mode_scanner: assert property (@(posedge aclk) disable iff (!aresetn)
        credit_mode_reg |-> (cur_target_reg == ucft_pkg::TGT_SCANNER))
        else $error("credit mode set without scanner target");

    // The received count never passes the announced size.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        received_reg <= total_size_reg)
        else $error("received bytes exceed upload size");

    // A pending credit is only reported while credit mode is in effect.
    a_pending_enabled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_grant_wait) |-> m_credit_enabled)
        else $error("pending credit reported without credit mode");

    // Granted bytes only come with an accepted request.
    a_allowed_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_allowed_bytes != '0)) |-> m_ok)
        else $error("allowed bytes on a refused request");

    // A stalled result does not let the input stage move on.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready && in_valid_reg) |=> (in_valid_reg && m_valid))
        else $error("input stage dropped a request during a stall");
`endif

endmodule
